@@ hdl/qfe_pkg.sv @@
// Shared widths, register indexes and delimiter codes for the query field extractor.
package qfe_pkg;

    localparam int BYTE_W     = 8;
    localparam int KEY_W      = 64;
    localparam int KLEN_W     = 4;
    localparam int CAP_W      = 16;
    localparam int CFG_IDX_W  = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [KLEN_W-1:0] klen_t;
    typedef logic [CAP_W-1:0]  count_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEARCH_KEY     = 2'd0,
        REG_KEY_LENGTH     = 2'd1,
        REG_VALUE_CAPACITY = 2'd2
    } cfg_reg_t;

    localparam byte_t CHAR_NUL       = 8'h00;
    localparam byte_t CHAR_AMPERSAND = 8'h26;
    localparam byte_t CHAR_COLON     = 8'h3A;
    localparam byte_t CHAR_SEMICOLON = 8'h3B;

    localparam count_t CAP_RESET = 16'd255;

    function automatic logic is_terminator(input byte_t b);
        return (b == CHAR_NUL) || (b == CHAR_AMPERSAND) ||
               (b == CHAR_COLON) || (b == CHAR_SEMICOLON);
    endfunction

endpackage

@@ hdl/query_field_extractor.sv @@
// Top level of the query field extractor: key search and value copy over a byte stream.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | s_byte_in
//  m_      | out       | m_valid / m_ready    | m_value_byte, m_is_value_byte, m_is_last,
//          |           |                      | m_found, m_value_length
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word per cycle while the output is not stalled: a word goes into the input
// register, is decided by the scan logic once it is there, and its result, if any,
// is loaded into the output register at the end of that cycle.
// Reset is synchronous and active low; it clears the scan state and loads the
// register defaults. A stalled output holds the input stage, and the input
// register then fills before s_ready drops.
module query_field_extractor #(
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  qfe_pkg::byte_t       s_byte_in,

    output logic                 m_valid,
    input  logic                 m_ready,
    output qfe_pkg::byte_t       m_value_byte,
    output logic                 m_is_value_byte,
    output logic                 m_is_last,
    output logic                 m_found,
    output qfe_pkg::count_t      m_value_length,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [qfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [qfe_pkg::KEY_W-1:0]     cfg_data
);
    import qfe_pkg::*;

    localparam int KEY_IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    typedef enum logic [1:0] {
        PH_MATCHING,
        PH_COPYING,
        PH_DONE
    } phase_t;

    byte_t  key_reg [MAX_KEY_BYTES];
    klen_t  key_length_reg;
    count_t value_capacity_reg;

    phase_t phase_reg, phase_next;
    klen_t  match_index_reg, match_index_next;
    count_t copied_count_reg, copied_count_next;

    logic   in_valid_reg;
    byte_t  in_byte_reg;

    logic   m_valid_reg, m_valid_next;
    byte_t  m_value_byte_reg, m_value_byte_next;
    logic   m_is_value_byte_reg, m_is_value_byte_next;
    logic   m_is_last_reg, m_is_last_next;
    logic   m_found_reg, m_found_next;
    count_t m_value_length_reg, m_value_length_next;

    logic   advance;
    logic   has_result;
    klen_t  klen;
    byte_t  key_byte;
    klen_t  match_inc;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    assign klen = (key_length_reg > KLEN_W'(MAX_KEY_BYTES)) ?
                  KLEN_W'(MAX_KEY_BYTES) : key_length_reg;
    assign key_byte  = key_reg[match_index_reg[KEY_IDX_W-1:0]];
    assign match_inc = match_index_reg + KLEN_W'(1);

    always_comb begin
        phase_next           = phase_reg;
        match_index_next     = match_index_reg;
        copied_count_next    = copied_count_reg;
        has_result           = 1'b0;
        m_value_byte_next    = '0;
        m_is_value_byte_next = 1'b0;
        m_is_last_next       = 1'b0;
        m_found_next         = 1'b0;
        m_value_length_next  = '0;

        if (phase_reg == PH_DONE) begin
            if (in_byte_reg == CHAR_NUL) begin
                phase_next        = PH_MATCHING;
                match_index_next  = '0;
                copied_count_next = '0;
            end
        end else if (phase_reg == PH_MATCHING && match_index_reg < klen) begin
            if (in_byte_reg == CHAR_NUL) begin
                has_result        = 1'b1;
                m_is_last_next    = 1'b1;
                match_index_next  = '0;
                copied_count_next = '0;
            end else if (in_byte_reg == key_byte) begin
                match_index_next = match_inc;
                if (match_inc >= klen) begin
                    phase_next        = PH_COPYING;
                    copied_count_next = '0;
                end
            end else begin
                match_index_next = '0;
            end
        end else begin
            has_result = 1'b1;
            if (is_terminator(in_byte_reg) || copied_count_reg >= value_capacity_reg) begin
                m_is_last_next      = 1'b1;
                m_found_next        = 1'b1;
                m_value_length_next = copied_count_reg;
                match_index_next    = '0;
                if (in_byte_reg == CHAR_NUL) begin
                    phase_next        = PH_MATCHING;
                    copied_count_next = '0;
                end else begin
                    phase_next = PH_DONE;
                end
            end else begin
                phase_next           = PH_COPYING;
                copied_count_next    = copied_count_reg + CAP_W'(1);
                m_value_byte_next    = in_byte_reg;
                m_is_value_byte_next = 1'b1;
            end
        end
    end

    always_comb begin
        if (advance && has_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_MATCHING;
            match_index_reg    <= '0;
            copied_count_reg   <= '0;
            in_valid_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
            key_length_reg     <= '0;
            value_capacity_reg <= CAP_RESET;
            for (int i = 0; i < MAX_KEY_BYTES; i++) begin
                key_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_SEARCH_KEY: begin
                        for (int i = 0; i < MAX_KEY_BYTES; i++) begin
                            key_reg[i] <= cfg_data[i*BYTE_W +: BYTE_W];
                        end
                    end
                    REG_KEY_LENGTH:     key_length_reg     <= cfg_data[KLEN_W-1:0];
                    REG_VALUE_CAPACITY: value_capacity_reg <= cfg_data[CAP_W-1:0];
                    default: ;
                endcase
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                phase_reg        <= phase_next;
                match_index_reg  <= match_index_next;
                copied_count_reg <= copied_count_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
        end
        if (advance && has_result) begin
            m_value_byte_reg    <= m_value_byte_next;
            m_is_value_byte_reg <= m_is_value_byte_next;
            m_is_last_reg       <= m_is_last_next;
            m_found_reg         <= m_found_next;
            m_value_length_reg  <= m_value_length_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_value_byte    = m_value_byte_reg;
    assign m_is_value_byte = m_is_value_byte_reg;
    assign m_is_last       = m_is_last_reg;
    assign m_found         = m_found_reg;
    assign m_value_length  = m_value_length_reg;

endmodule

@@ hdl/qfe_checker.sv @@
// Port-level assertions for the query field extractor and the bind that attaches them.
module qfe_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  qfe_pkg::byte_t       m_value_byte,
    input  logic                 m_is_value_byte,
    input  logic                 m_is_last,
    input  logic                 m_found,
    input  qfe_pkg::count_t      m_value_length
);
    import qfe_pkg::*;

    // A result word is either a value byte or the closing word, never both or neither.
    a_kind_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_value_byte != m_is_last))
        else $error("result word kind is ambiguous");

    // A copied byte is never a delimiter or the terminating zero.
    a_value_not_delim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_value_byte |->
            m_value_byte != CHAR_NUL && m_value_byte != CHAR_AMPERSAND &&
            m_value_byte != CHAR_COLON && m_value_byte != CHAR_SEMICOLON &&
            !m_found && m_value_length == '0)
        else $error("value byte word carries a delimiter or summary fields");

    // A closing word without a match reports no value bytes.
    a_not_found_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_last && !m_found |-> m_value_length == '0)
        else $error("not-found word reports a value length");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_byte) &&
            $stable(m_is_value_byte) && $stable(m_is_last) &&
            $stable(m_found) && $stable(m_value_length))
        else $error("stalled result word changed");

endmodule

bind query_field_extractor qfe_checker u_qfe_checker (.*);
